// ----- sv/pulse_beat_detector_top_defines.svh -----
// Assertion macros used by the pulse beat detector RTL.
`ifndef PULSE_BEAT_DETECTOR_TOP_DEFINES_SVH
`define PULSE_BEAT_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication
`define PBD_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("pulse beat detector assertion failed");

// next-cycle implication
`define PBD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("pulse beat detector assertion failed");

`endif

// ----- sv/pbd_pkg.sv -----
// Package of the pulse beat detector: widths, codes, tap weights and microcode.
package pbd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int DC_SHIFT    = 4;
	localparam int DELAY_DEPTH = 32;
	localparam int FRAC        = 15;
	localparam int FIR_HALF    = 11;

	localparam int DC_W    = SAMPLE_BITS + FRAC;
	localparam int DLY_W   = SAMPLE_BITS + 1;
	localparam int SUM_W   = SAMPLE_BITS + 2;
	localparam int WGT_W   = 13;
	localparam int PROD_W  = SUM_W + WGT_W + 1;
	localparam int ACC_W   = 34;
	localparam int OUT_W   = 18;
	localparam int LIM_W   = 18;
	localparam int IDX_W   = $clog2(DELAY_DEPTH);
	localparam int PAIR_W  = $clog2(FIR_HALF + 1);
	localparam int CFG_IDX_W = 4;

	localparam int FIRST_RD  = 2;
	localparam int LAST_RD   = FIRST_RD + FIR_HALF;
	localparam int LAST_STEP = LAST_RD + 3;
	localparam int STEP_W    = $clog2(LAST_STEP + 1);

	localparam logic [LIM_W-1:0] LOWER_RESET = LIM_W'(1000);
	localparam logic [LIM_W-1:0] UPPER_RESET = LIM_W'(3000);

	localparam logic [CFG_IDX_W-1:0] REG_SWING_LOWER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SWING_UPPER = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		OP_ACCEPT,
		OP_DC,
		OP_NOP,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		WT_NONE,
		WT_IN,
		WT_OUT
	} wait_t;

	typedef struct packed {
		op_t               op;
		wait_t             wt;
		logic              last;
		logic              rd;
		logic [PAIR_W-1:0] pair;
	} cw_t;

	function automatic logic [WGT_W-1:0] tap_weight(input logic [PAIR_W-1:0] idx);
		logic [WGT_W-1:0] w;
		case (idx)
			PAIR_W'(0):  w = WGT_W'(172);
			PAIR_W'(1):  w = WGT_W'(321);
			PAIR_W'(2):  w = WGT_W'(579);
			PAIR_W'(3):  w = WGT_W'(927);
			PAIR_W'(4):  w = WGT_W'(1360);
			PAIR_W'(5):  w = WGT_W'(1858);
			PAIR_W'(6):  w = WGT_W'(2390);
			PAIR_W'(7):  w = WGT_W'(2916);
			PAIR_W'(8):  w = WGT_W'(3391);
			PAIR_W'(9):  w = WGT_W'(3768);
			PAIR_W'(10): w = WGT_W'(4012);
			PAIR_W'(11): w = WGT_W'(4096);
			default:     w = '0;
		endcase
		return w;
	endfunction

	function automatic cw_t ucode(input logic [STEP_W-1:0] step);
		cw_t cw;
		cw = '{op: OP_NOP, wt: WT_NONE, last: 1'b0, rd: 1'b0, pair: '0};
		case (step) inside
			STEP_W'(0): begin
				cw.op = OP_ACCEPT;
				cw.wt = WT_IN;
			end
			STEP_W'(1): begin
				cw.op = OP_DC;
			end
			[STEP_W'(FIRST_RD):STEP_W'(LAST_RD)]: begin
				cw.rd   = 1'b1;
				cw.pair = PAIR_W'(step - STEP_W'(FIRST_RD));
			end
			STEP_W'(LAST_STEP): begin
				cw.op   = OP_OUT;
				cw.wt   = WT_OUT;
				cw.last = 1'b1;
			end
			default: begin
				cw.op = OP_NOP;
			end
		endcase
		return cw;
	endfunction

endpackage

// ----- sv/pulse_beat_detector_top.sv -----
// Pulse beat detector: one optical sample in, one filtered value and beat flag out.
//
// Input channel in_valid/in_ready carries one unsigned sample per item.
// Output channel out_valid/out_ready carries beat and filtered_value.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// swing limits (index 0 lower, index 1 upper); it is always ready, and
// writes to other indexes are dropped. Write it only while idle.
// A microcode table steps through 17 control words per item: accept,
// DC update and delay line write, twelve tap-pair reads of the two-port
// delay line memory, two steps to drain the single shared multiplier and
// accumulator, then the zero-crossing step that loads the result.
// A new item is accepted only after the final step of the one before,
// as the one multiplier is shared over the twelve pairs.
// The input is accepted while an earlier result still waits in the output
// register; if the receiver stalls, the final step holds until that
// result is taken. Reset clears the filter state, the delay line valid
// bits and the limits to 1000 and 3000; no clearing pass is needed.
module pulse_beat_detector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pbd_pkg::SAMPLE_BITS-1:0]     sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                beat,
	output logic signed [pbd_pkg::OUT_W-1:0]    filtered_value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pbd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pbd_pkg::LIM_W-1:0]           cfg_data
);
	import pbd_pkg::*;

	`include "pulse_beat_detector_top_defines.svh"

	logic [STEP_W-1:0]          step_q;
	cw_t                        cw;
	logic                       out_busy;
	logic                       stay;
	logic                       do_out;
	logic                       in_acc;

	logic [LIM_W-1:0]           lower_q;
	logic [LIM_W-1:0]           upper_q;

	logic [SAMPLE_BITS-1:0]     sample_q;
	logic [DC_W-1:0]            dc_q;
	logic signed [DC_W+1:0]     dc_diff;
	logic signed [DC_W+1:0]     dc_next;
	logic signed [DLY_W-1:0]    dly_val;
	logic [IDX_W-1:0]           widx_q;

	logic signed [DLY_W-1:0]    mem [DELAY_DEPTH];
	logic [DELAY_DEPTH-1:0]     vld_q;
	logic [IDX_W-1:0]           addr_a;
	logic [IDX_W-1:0]           addr_b;

	logic signed [DLY_W-1:0]    a_s1;
	logic signed [DLY_W-1:0]    b_s1;
	logic                       va_s1;
	logic                       vb_s1;
	logic                       rd_s1;
	logic [PAIR_W-1:0]          pair_s1;
	logic signed [DLY_W-1:0]    ta;
	logic signed [DLY_W-1:0]    tb;
	logic signed [SUM_W-1:0]    pair_sum;

	logic signed [PROD_W-1:0]   prod_s2;
	logic                       prod_v_s2;
	logic signed [ACC_W-1:0]    acc_q;

	logic signed [OUT_W-1:0]    cur;
	logic signed [OUT_W-1:0]    prev_q;
	logic signed [OUT_W-1:0]    peak_q;
	logic signed [OUT_W-1:0]    trough_q;
	logic                       pos_q;
	logic                       neg_q;
	logic signed [OUT_W-1:0]    peak_n;
	logic signed [OUT_W-1:0]    trough_n;
	logic                       pos_n;
	logic                       neg_n;
	logic                       rise;
	logic                       fall;
	logic signed [OUT_W:0]      swing;
	logic                       beat_n;

	// sequencer
	always_comb begin
		cw       = ucode(step_q);
		out_busy = out_valid && !out_ready;
		in_ready = (cw.op == OP_ACCEPT);
		in_acc   = in_valid && in_ready;
		stay     = ((cw.wt == WT_IN) && !in_valid) || ((cw.wt == WT_OUT) && out_busy);
		do_out   = (cw.op == OP_OUT) && !out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (!stay) begin
			step_q <= cw.last ? '0 : step_q + STEP_W'(1);
		end
	end

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LOWER_RESET;
			upper_q <= UPPER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SWING_LOWER: lower_q <= cfg_data;
				REG_SWING_UPPER: upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// DC removal
	always_comb begin
		dc_diff = $signed({2'b00, sample_q, {FRAC{1'b0}}}) - $signed({2'b00, dc_q});
		dc_next = $signed({2'b00, dc_q}) + (dc_diff >>> DC_SHIFT);
		dly_val = $signed({1'b0, sample_q}) - $signed({1'b0, dc_next[DC_W-1:FRAC]});
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q   <= '0;
			widx_q <= '0;
			vld_q  <= '0;
		end else begin
			if (cw.op == OP_DC) begin
				dc_q          <= dc_next[DC_W-1:0];
				vld_q[widx_q] <= 1'b1;
			end
			if (do_out) begin
				widx_q <= widx_q + IDX_W'(1);
			end
		end
	end

	// delay line memory, two read ports
	always_comb begin
		addr_a = widx_q - IDX_W'(cw.pair);
		addr_b = widx_q - IDX_W'(2 * FIR_HALF) + IDX_W'(cw.pair);
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_DC) begin
			mem[widx_q] <= dly_val;
		end
		if (cw.rd) begin
			a_s1    <= mem[addr_a];
			b_s1    <= mem[addr_b];
			pair_s1 <= cw.pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			va_s1 <= 1'b0;
			vb_s1 <= 1'b0;
		end else begin
			rd_s1 <= cw.rd;
			if (cw.rd) begin
				va_s1 <= vld_q[addr_a];
				vb_s1 <= vld_q[addr_b];
			end
		end
	end

	// shared multiply-accumulate
	always_comb begin
		ta = va_s1 ? a_s1 : '0;
		tb = (vb_s1 && (pair_s1 != PAIR_W'(FIR_HALF))) ? b_s1 : '0;
		pair_sum = SUM_W'(ta) + SUM_W'(tb);
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			prod_s2 <= PROD_W'(pair_sum) * $signed({1'b0, tap_weight(pair_s1)});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
			acc_q     <= '0;
		end else begin
			prod_v_s2 <= rd_s1;
			if (cw.op == OP_DC) begin
				acc_q <= '0;
			end else if (prod_v_s2) begin
				acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
			end
		end
	end

	// zero crossing and swing check
	always_comb begin
		cur   = acc_q[FRAC+OUT_W-1:FRAC];
		rise  = (prev_q < 0) && (cur >= 0);
		fall  = (prev_q > 0) && (cur <= 0);
		swing = $signed({peak_q[OUT_W-1], peak_q}) - $signed({trough_q[OUT_W-1], trough_q});
		beat_n = rise && (swing > $signed({1'b0, lower_q}))
			&& (swing < $signed({1'b0, upper_q}));
		pos_n    = rise ? 1'b1 : (fall ? 1'b0 : pos_q);
		neg_n    = rise ? 1'b0 : (fall ? 1'b1 : neg_q);
		peak_n   = rise ? '0 : peak_q;
		trough_n = fall ? '0 : trough_q;
		if (pos_n && (cur > prev_q)) begin
			peak_n = cur;
		end
		if (neg_n && (cur < prev_q)) begin
			trough_n = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			peak_q   <= '0;
			trough_q <= '0;
			pos_q    <= 1'b0;
			neg_q    <= 1'b0;
		end else if (do_out) begin
			prev_q   <= cur;
			peak_q   <= peak_n;
			trough_q <= trough_n;
			pos_q    <= pos_n;
			neg_q    <= neg_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (do_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_out) begin
			beat           <= beat_n;
			filtered_value <= cur;
		end
	end

	`PBD_ASSERT_NEXT(a_accept_to_dc, clk, arst_n, in_acc, (step_q == STEP_W'(1)))
	`PBD_ASSERT_NOW(a_dc_pipe_empty, clk, arst_n, (cw.op == OP_DC), (!rd_s1 && !prod_v_s2))
	`PBD_ASSERT_NOW(a_out_pipe_empty, clk, arst_n, (cw.op == OP_OUT), (!rd_s1 && !prod_v_s2))
	`PBD_ASSERT_NOW(a_step_bound, clk, arst_n, 1'b1, (step_q <= STEP_W'(LAST_STEP)))

endmodule

// ----- dv/tb_top.sv -----
// Testbench of the pulse beat detector: drives samples and swing limits, checks every result.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pbd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int QUIET_LO    = 5000;
	localparam int QUIET_HI    = 10000;
	localparam int PHASE_ITEMS = 125;
	localparam logic [LIM_W-1:0]       LIM_MAX     = '1;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = '1;
	localparam logic [CFG_IDX_W-1:0]   CFG_IDX_MAX = '1;

	typedef struct packed {
		logic                    beat;
		logic signed [OUT_W-1:0] level;
	} beat_result_t;

	logic                          clk            = 1'b0;
	logic                          arst_n         = 1'b0;
	logic                          in_valid       = 1'b0;
	logic                          in_ready;
	logic [SAMPLE_BITS-1:0]        sample         = '0;
	logic                          out_valid;
	logic                          out_ready      = 1'b0;
	logic                          beat;
	logic signed [OUT_W-1:0]       filtered_value;
	logic                          cfg_valid      = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index      = '0;
	logic [LIM_W-1:0]              cfg_data       = '0;

	int cycle_count = 0;
	int err_count   = 0;

	logic [SAMPLE_BITS-1:0] sample_backlog [$];
	beat_result_t           expected_beats [$];

	// detector state as seen by the checker
	int                      fir_coef [0:FIR_HALF] = '{172, 321, 579, 927, 1360, 1858,
		2390, 2916, 3391, 3768, 4012, 4096};
	logic [DC_W-1:0]         dc_level_q    = '0;
	logic signed [DLY_W-1:0] hp_line_q [DELAY_DEPTH];
	logic [IDX_W-1:0]        wr_ptr_q      = '0;
	logic signed [OUT_W-1:0] prev_level_q  = '0;
	logic signed [OUT_W-1:0] peak_q        = '0;
	logic signed [OUT_W-1:0] trough_q      = '0;
	logic                    rising_half_q  = 1'b0;
	logic                    falling_half_q = 1'b0;
	logic [LIM_W-1:0]        lower_lim     = LOWER_RESET;
	logic [LIM_W-1:0]        upper_lim     = UPPER_RESET;

	pulse_beat_detector_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.beat           (beat),
		.filtered_value (filtered_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic bit take_break();
		return (cycle_count < QUIET_LO || cycle_count >= QUIET_HI)
			&& ($urandom_range(0, 99) < 6);
	endfunction

	function automatic beat_result_t track_pulse(input logic [SAMPLE_BITS-1:0] smp);
		longint       x;
		longint       gap;
		longint       acc;
		longint       cur;
		longint       prev;
		longint       swing;
		beat_result_t res;
		x          = longint'(smp);
		gap        = (x <<< FRAC) - longint'(dc_level_q);
		dc_level_q = DC_W'(longint'(dc_level_q) + (gap >>> DC_SHIFT));
		hp_line_q[wr_ptr_q] = DLY_W'(x - longint'(dc_level_q >> FRAC));
		acc = longint'(fir_coef[FIR_HALF])
			* longint'(hp_line_q[IDX_W'(wr_ptr_q - FIR_HALF)]);
		for (int i = 0; i < FIR_HALF; i++)
			acc += longint'(fir_coef[i])
				* (longint'(hp_line_q[IDX_W'(wr_ptr_q - i)])
				+ longint'(hp_line_q[IDX_W'(wr_ptr_q - 2 * FIR_HALF + i)]));
		wr_ptr_q = wr_ptr_q + 1'b1;
		cur      = acc >>> FRAC;
		prev     = longint'(prev_level_q);
		res.beat = 1'b0;
		if (prev < 0 && cur >= 0) begin
			swing          = longint'(peak_q) - longint'(trough_q);
			rising_half_q  = 1'b1;
			falling_half_q = 1'b0;
			peak_q         = '0;
			if (swing > longint'(lower_lim) && swing < longint'(upper_lim))
				res.beat = 1'b1;
		end
		if (prev > 0 && cur <= 0) begin
			rising_half_q  = 1'b0;
			falling_half_q = 1'b1;
			trough_q       = '0;
		end
		if (rising_half_q && cur > prev)
			peak_q = OUT_W'(cur);
		if (falling_half_q && cur < prev)
			trough_q = OUT_W'(cur);
		prev_level_q = OUT_W'(cur);
		res.level    = OUT_W'(cur);
		return res;
	endfunction

	// sample driver; predict each item as it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_beats.push_back(track_pulse(sample));
			if (!in_valid || in_ready) begin
				if (sample_backlog.size() != 0 && !take_break()) begin
					in_valid <= 1'b1;
					sample   <= sample_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= arst_n && !take_break();
	end

	always @(posedge clk) begin
		beat_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				err_count++;
				$display("%0t: unexpected item, beat %0b filtered_value %0d",
					$time, beat, filtered_value);
			end else begin
				want = expected_beats.pop_front();
				if (want.beat !== beat || want.level !== filtered_value) begin
					err_count++;
					$display("%0t: mismatch, expected beat %0b filtered_value %0d, got beat %0b filtered_value %0d",
						$time, want.beat, $signed(want.level), beat, filtered_value);
				end
			end
		end
	end

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_SWING_LOWER)
			lower_lim = val;
		else if (idx == REG_SWING_UPPER)
			upper_lim = val;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (sample_backlog.size() != 0 || in_valid || expected_beats.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_wave(input int count);
		int base;
		int amp;
		int period;
		int jitter;
		int ph;
		int tri_val;
		int noise;
		int val;
		base   = $urandom_range(2000, 63000);
		amp    = ($urandom_range(0, 9) == 0) ? $urandom_range(3000, 40000)
			: $urandom_range(40, 2500);
		period = $urandom_range(6, 48);
		jitter = $urandom_range(0, 30);
		for (int t = 0; t < count; t++) begin
			ph      = t % period;
			tri_val = (ph < period / 2) ? ph : period - ph;
			noise   = $urandom_range(0, 2 * jitter);
			noise   = noise - jitter;
			val     = base - amp / 2 + (tri_val * 2 * amp) / period + noise;
			if (val < 0)
				val = 0;
			if (val > 65535)
				val = 65535;
			sample_backlog.push_back(SAMPLE_BITS'(val));
		end
	endtask

	task automatic queue_burst(input int count);
		int mode;
		int base;
		mode = $urandom_range(0, 2);
		base = $urandom_range(0, 65535);
		for (int t = 0; t < count; t++) begin
			case (mode)
				0: sample_backlog.push_back(SAMPLE_BITS'($urandom_range(0, 65535)));
				1: sample_backlog.push_back(($urandom_range(0, 1) == 1) ? SAMPLE_MAX : '0);
				default: sample_backlog.push_back(SAMPLE_BITS'(base + $urandom_range(0, 3)));
			endcase
		end
	endtask

	task automatic queue_random(input int total);
		int n;
		int len;
		n = 0;
		while (n < total) begin
			if ($urandom_range(0, 99) < 70) begin
				len = $urandom_range(30, 90);
				if (len > total - n)
					len = total - n;
				queue_wave(len);
			end else begin
				len = $urandom_range(4, 16);
				if (len > total - n)
					len = total - n;
				queue_burst(len);
			end
			n += len;
		end
	endtask

	initial begin
		logic [LIM_W-1:0] lower_set [6];
		logic [LIM_W-1:0] upper_set [6];
		lower_set = '{'0, LIM_MAX, LIM_W'(500), LIM_W'(200), LIM_W'(1500),
			LIM_W'($urandom_range(0, 3000))};
		upper_set = '{LIM_MAX, '0, LIM_W'(500), LIM_W'(4000), LIM_W'(2500),
			LIM_W'($urandom_range(500, 8000))};
		foreach (hp_line_q[i])
			hp_line_q[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// full-scale steps, toggling, then a short moderate swing
		repeat (6) sample_backlog.push_back(SAMPLE_MAX);
		repeat (6) sample_backlog.push_back('0);
		for (int k = 0; k < 6; k++)
			sample_backlog.push_back(k[0] ? SAMPLE_MAX : SAMPLE_BITS'(0));
		for (int k = 0; k < 7; k++)
			sample_backlog.push_back(SAMPLE_BITS'(32768 + ((k < 4) ? k : 7 - k) * 400));
		wait_drained();
		for (int p = 0; p < 6; p++) begin
			write_limit(REG_SWING_LOWER, lower_set[p]);
			write_limit(REG_SWING_UPPER, upper_set[p]);
			if (p == 0)
				write_limit(CFG_IDX_MAX, LIM_MAX);
			else
				write_limit(CFG_IDX_W'($urandom_range(REG_SWING_UPPER + 1, CFG_IDX_MAX)),
					LIM_W'($urandom));
			@(negedge clk);
			queue_random(PHASE_ITEMS);
			wait_drained();
		end
		repeat (40) @(posedge clk);
		err_count += expected_beats.size();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/pbd_pkg.sv
sv/pulse_beat_detector_top.sv
dv/tb_top.sv
